@@ design/weighted_rank_bisection_unit_assert.svh @@
// Assertion macros for the bisection unit.
`ifndef WEIGHTED_RANK_BISECTION_UNIT_ASSERT_SVH
`define WEIGHTED_RANK_BISECTION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrb assertion failed");

// Next-cycle implication.
`define WRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrb assertion failed");

`endif

@@ design/wrb_pkg.sv @@
`timescale 1ns / 1ps
package wrb_pkg;

  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int COORD_W         = 32;
  localparam int WEIGHT_W        = 16;
  localparam int INDEX_W         = 10;
  localparam int TARGET_W        = 26;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NONE    = 2'd3
  } act_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TARGET  = 8'd0,
    CFG_USE_WGT = 8'd1
  } cfg_reg_t;

  localparam logic RES_CUT  = 1'b0;
  localparam logic RES_SIDE = 1'b1;

endpackage

@@ design/weighted_rank_bisection_unit.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Handshake                | Payload
// s       | in  | s_tvalid / s_tready      | s_tuser action, s_tdata coord/weight/entry_index
// m       | out | m_tvalid / m_tready      | m_tuser result_kind, m_tdata threshold/side/status
// cfg     | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
// Load: written into the memory on acceptance. Read: memory read, compare, output register.
// Compute: one pass over the N stored entries per coordinate bit through the
// single memory read port; no pass at all if the total weight does not exceed
// the target or the store is empty.
// rst clears count, weight sum, cut, config registers and control; the memory is not cleared.
// A held result in the output register stalls the next result in S_EMIT, and the input with it.
module weighted_rank_bisection_unit
  import wrb_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [63:0]            s_tdata,   // coord[31:0], weight[47:32], entry_index[57:48]
  input  logic [1:0]             s_tuser,   // action[1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [39:0]            m_tdata,   // threshold[31:0], side[32], status[33]
  output logic                   m_tuser,   // result_kind[0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int SW   = WEIGHT_W + CW;
  localparam int CMPW = (SW > TARGET_W) ? SW : TARGET_W;
  localparam int BW   = $clog2(COORD_W);
  localparam int MW   = COORD_W + WEIGHT_W;
  localparam logic [COORD_W-1:0] SIGN_BIT = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_EMIT} state_t;

  state_t                     state;
  logic [MW-1:0]              mem [MAX_ENTRIES];
  logic [MW-1:0]              rdata;
  logic [AW-1:0]              raddr;
  logic [CW-1:0]              count;
  logic [SW-1:0]              wsum;
  logic signed [COORD_W-1:0]  max_coord;
  logic signed [COORD_W-1:0]  cut;
  logic [TARGET_W-1:0]        target;
  logic                       use_w;
  logic [CW-1:0]              ai;
  logic                       issuing;
  logic                       rd_v;
  logic                       rd_last;
  logic [CMPW-1:0]            acc;
  logic [COORD_W-1:0]         pbits;
  logic [BW-1:0]              bitn;
  logic                       pend_kind;
  logic [COORD_W-1:0]         pend_thr;
  logic                       pend_side;
  logic                       pend_status;

  act_t                       in_act;
  logic signed [COORD_W-1:0]  in_coord;
  logic [WEIGHT_W-1:0]        in_weight;
  logic [INDEX_W-1:0]         in_idx;
  logic                       in_xfer;
  logic                       full;
  logic                       mem_we;
  logic [CMPW-1:0]            total;
  logic [CMPW-1:0]            target_ext;
  logic [COORD_W-1:0]         probe;
  logic signed [COORD_W-1:0]  r_coord;
  logic [WEIGHT_W-1:0]        r_w;
  logic                       hit;
  logic [CMPW-1:0]            acc_sum;
  logic [COORD_W-1:0]         pnew;

  assign s_tready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_act     = act_t'(s_tuser);
  assign in_coord   = s_tdata[31:0];
  assign in_weight  = s_tdata[47:32];
  assign in_idx     = s_tdata[57:48];
  assign in_xfer    = s_tvalid && s_tready;
  assign full       = (count == CW'(MAX_ENTRIES));
  assign mem_we     = in_xfer && (in_act == ACT_LOAD) && !full;
  assign total      = use_w ? CMPW'(wsum) : CMPW'(count);
  assign target_ext = CMPW'(target);
  assign probe      = pbits | ((COORD_W'(1) << bitn) - COORD_W'(1));
  assign r_coord    = rdata[MW-1:WEIGHT_W];
  assign r_w        = rdata[WEIGHT_W-1:0];
  assign hit        = (COORD_W'(r_coord) ^ SIGN_BIT) <= probe;
  assign acc_sum    = acc + (hit ? (use_w ? CMPW'(r_w) : CMPW'(1)) : CMPW'(0));
  assign pnew       = (acc_sum > target_ext) ? pbits : (pbits | (COORD_W'(1) << bitn));
  assign raddr      = (state == S_SCAN) ? AW'(ai) : AW'(in_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(count)] <= {in_coord, in_weight};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      use_w  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET:  target <= cfg_data[TARGET_W-1:0];
        CFG_USE_WGT: use_w  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wsum      <= '0;
      cut       <= '0;
      m_tvalid  <= 1'b0;
      issuing   <= 1'b0;
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_act)
              ACT_LOAD: begin
                if (!full) begin
                  count <= count + CW'(1);
                  wsum  <= wsum + SW'(in_weight);
                  if (count == '0 || in_coord > max_coord) begin
                    max_coord <= in_coord;
                  end
                end
              end
              ACT_COMPUTE: begin
                pend_kind <= RES_CUT;
                pend_side <= 1'b0;
                if (count == '0) begin
                  pend_thr    <= '0;
                  pend_status <= 1'b1;
                  state       <= S_EMIT;
                end else if (total <= target_ext) begin
                  cut         <= max_coord;
                  pend_thr    <= max_coord;
                  pend_status <= 1'b0;
                  state       <= S_EMIT;
                end else begin
                  pbits   <= '0;
                  bitn    <= BW'(COORD_W - 1);
                  ai      <= '0;
                  acc     <= '0;
                  issuing <= 1'b1;
                  state   <= S_SCAN;
                end
              end
              ACT_READ: begin
                pend_kind <= RES_SIDE;
                pend_thr  <= '0;
                if (32'(in_idx) >= 32'(count)) begin
                  pend_side   <= 1'b0;
                  pend_status <= 1'b1;
                  state       <= S_EMIT;
                end else begin
                  pend_status <= 1'b0;
                  state       <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            rd_v    <= 1'b1;
            rd_last <= (ai == count - CW'(1));
            ai      <= ai + CW'(1);
            if (ai == count - CW'(1)) begin
              issuing <= 1'b0;
            end
          end else begin
            rd_v <= 1'b0;
          end
          if (rd_v) begin
            if (rd_last) begin
              acc   <= '0;
              pbits <= pnew;
              if (bitn == '0) begin
                cut         <= pnew ^ SIGN_BIT;
                pend_thr    <= pnew ^ SIGN_BIT;
                pend_status <= 1'b0;
                state       <= S_EMIT;
              end else begin
                bitn    <= bitn - BW'(1);
                ai      <= '0;
                issuing <= 1'b1;
              end
            end else begin
              acc <= acc_sum;
            end
          end
        end
        S_READ: begin
          pend_side <= (r_coord < cut);
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= pend_kind;
            m_tdata  <= {6'b0, pend_status, pend_side, pend_thr};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "weighted_rank_bisection_unit_assert.svh"

  `WRB_ASSERT_NOW(a_count_bound, 1'b1, 32'(count) <= 32'(MAX_ENTRIES))
  `WRB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `WRB_ASSERT_NEXT(a_load_count, mem_we, count == CW'($past(count) + CW'(1)))

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import wrb_pkg::*;

  localparam int MAX_N = DEF_MAX_ENTRIES;
  localparam longint CYCLE_LIMIT = 64'd4000000;

  typedef struct packed {
    logic        kind;
    logic [31:0] threshold;
    logic        side;
    logic        status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0] s_tuser = ACT_NONE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  weighted_rank_bisection_unit dut (.*);

  // predictor state
  logic signed [31:0] coords [MAX_N];
  logic [15:0] weights [MAX_N];
  int unsigned n_loaded;
  logic signed [31:0] cut;
  logic [25:0] target;
  logic use_wgt;
  answer_t expected_answers[$];

  int errors = 0;
  int n_items = 0, n_cuts = 0, n_sides = 0;
  longint cycles = 0;
  bit stall_en = 1'b1;
  int stall_left = 0;

  function automatic logic signed [31:0] find_cut();
    logic signed [31:0] best, maxc, c;
    bit found;
    longint unsigned w;
    found = 1'b0;
    best = 0;
    maxc = coords[0];
    for (int i = 0; i < n_loaded; i++) begin
      c = coords[i];
      if (c > maxc) maxc = c;
      w = 0;
      for (int j = 0; j < n_loaded; j++)
        if (coords[j] <= c) w += use_wgt ? weights[j] : 1;
      if (w > target && (!found || c < best)) begin
        best = c;
        found = 1'b1;
      end
    end
    return found ? best : maxc;
  endfunction

  function automatic void predict(act_t a, logic [31:0] c, logic [15:0] w, logic [9:0] idx);
    answer_t r;
    r = '0;
    case (a)
      ACT_LOAD: begin
        if (n_loaded < MAX_N) begin
          coords[n_loaded] = c;
          weights[n_loaded] = w;
          n_loaded++;
        end
      end
      ACT_COMPUTE: begin
        r.kind = RES_CUT;
        if (n_loaded == 0) r.status = 1'b1;
        else begin
          cut = find_cut();
          r.threshold = cut;
        end
        expected_answers.push_back(r);
      end
      ACT_READ: begin
        r.kind = RES_SIDE;
        if (idx >= n_loaded) r.status = 1'b1;
        else r.side = coords[idx] < cut;
        expected_answers.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("weighted_rank_bisection_unit: mismatch");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[33]};
      if (expected_answers.size() == 0) begin
        $display("%0t unexpected transfer: %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_answers.pop_front();
        if (got.kind != exp_r.kind) begin
          $display("%0t kind exp %0d got %0d", $time, exp_r.kind, got.kind);
          errors++;
        end
        if (got.threshold != exp_r.threshold) begin
          $display("%0t threshold exp %h got %h", $time, exp_r.threshold, got.threshold);
          errors++;
        end
        if (got.side != exp_r.side) begin
          $display("%0t side exp %0d got %0d", $time, exp_r.side, got.side);
          errors++;
        end
        if (got.status != exp_r.status) begin
          $display("%0t status exp %0d got %0d", $time, exp_r.status, got.status);
          errors++;
        end
        if (got.kind == RES_CUT) n_cuts++;
        else n_sides++;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!stall_en) m_tready <= 1'b1;
    else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < 15) begin
      m_tready <= 1'b0;
      stall_left = gap_len();
    end else m_tready <= 1'b1;
  end

  task automatic send_item(act_t a, logic [31:0] c, logic [15:0] w, logic [9:0] idx);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= a;
    s_tdata <= {6'b0, idx, w, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(a, c, w, idx);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (r == CFG_TARGET) target = v[25:0];
    else use_wgt = v[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(ACT_COMPUTE, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_LOAD, 32'h7FFF_FFFF, 16'hFFFF, 10'h3FF);
    send_item(ACT_LOAD, 32'h8000_0000, 16'h0000, 0);
    send_item(ACT_LOAD, 32'h0001_0000, 16'h0001, 0);
    send_item(ACT_LOAD, 32'hFFFF_FFFF, 16'h8000, 0);
    send_item(ACT_READ, 0, 0, 10'd1);
    send_item(ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
    send_item(ACT_COMPUTE, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_item(ACT_READ, 0, 0, 10'(i));
    send_item(ACT_READ, 0, 0, 10'd4);
    send_item(ACT_READ, 0, 0, 10'h3FF);
    drain();
    write_reg(CFG_USE_WGT, 32'hFFFF_FFFF);
    write_reg(CFG_TARGET, 32'hFFFF_FFFF);
    send_item(ACT_COMPUTE, 0, 0, 0);
    drain();
    write_reg(CFG_TARGET, 32'd40000);
    send_item(ACT_COMPUTE, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 10'd2);
    drain();
  endtask

  // adds random points (duplicates common) and queries the store
  task automatic test_random_sets(int rounds);
    int n;
    logic [31:0] c;
    for (int r = 0; r < rounds; r++) begin
      drain();
      write_reg(CFG_USE_WGT, $urandom_range(1));
      case ($urandom_range(3))
        0: write_reg(CFG_TARGET, 0);
        1: write_reg(CFG_TARGET, 32'h03FF_FFFF);
        2: write_reg(CFG_TARGET, $urandom_range(12));
        default: write_reg(CFG_TARGET, $urandom_range(300000));
      endcase
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        c = ($urandom_range(2) == 0) ? $urandom() : $signed($urandom_range(8)) - 4;
        send_item(ACT_LOAD, c,
                  ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(3)),
                  10'($urandom()));
      end
      if ($urandom_range(7) == 0)
        send_item(ACT_NONE, $urandom(), 16'($urandom()), 10'($urandom()));
      send_item(ACT_COMPUTE, $urandom(), 16'($urandom()), 10'($urandom()));
      for (int i = 0; i < 4; i++)
        send_item(ACT_READ, $urandom(), 16'($urandom()),
                  ($urandom_range(5) == 0) ? 10'($urandom()) : 10'($urandom_range(n_loaded)));
    end
  endtask

  // fills the store past capacity; loads beyond it are dropped
  task automatic test_full_store();
    drain();
    write_reg(CFG_TARGET, 32'd512);
    write_reg(CFG_USE_WGT, 0);
    stall_en = 1'b0;
    while (n_loaded < MAX_N) send_item(ACT_LOAD, $urandom(), 16'($urandom()), 0);
    stall_en = 1'b1;
    send_item(ACT_LOAD, 32'h8000_0000, 16'hFFFF, 0);
    send_item(ACT_COMPUTE, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 10'h3FF);
    send_item(ACT_READ, 0, 0, 10'd0);
    drain();
  endtask

  initial begin
    n_loaded = 0;
    cut = 0;
    target = 0;
    use_wgt = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_sets(10);
    test_full_store();
    drain();
    $display("%0d items sent, %0d cut and %0d side answers checked,", n_items, n_cuts, n_sides);
    $display("including an overfilled store and both weighting modes");
    if (errors == 0) $display("weighted_rank_bisection_unit: match");
    else $display("weighted_rank_bisection_unit: mismatch");
    $finish;
  end
endmodule
